// ===== hdl/vvc_pkg.sv =====
// Package for the voxel visibility cull block: codes, register indexes and the state type.
`default_nettype none
package vvc_pkg;

  // Item operation codes.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_HEIGHT = 1'd1;

  // Register widths and reset values.
  localparam int                    CHUNK_WIDTH_W    = 5;
  localparam int                    CHUNK_HEIGHT_W   = 9;
  localparam logic [CHUNK_WIDTH_W-1:0]  CHUNK_WIDTH_RST  = 5'd16;
  localparam logic [CHUNK_HEIGHT_W-1:0] CHUNK_HEIGHT_RST = 9'd256;

  // Item field widths.
  localparam int X_W = 4;
  localparam int Y_W = 8;
  localparam int Z_W = 4;

  // A query reads the centre row and then, for an interior cell, four neighbour rows.
  localparam int          QRY_CNT_W = 3;
  localparam int          QRY_READS = 5;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE_RD,
    ST_WRITE_WB,
    ST_QUERY,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/vvc_in_if.sv =====
// Input item channel of the voxel visibility cull block.
`default_nettype none
interface vvc_in_if;
  import vvc_pkg::*;

  logic             valid;
  logic             ready;
  opcode_t          opcode;
  logic [X_W-1:0]   x_coord;
  logic [Y_W-1:0]   y_coord;
  logic [Z_W-1:0]   z_coord;
  logic             is_air;

  modport source (output valid, opcode, x_coord, y_coord, z_coord, is_air, input ready);
  modport sink   (input valid, opcode, x_coord, y_coord, z_coord, is_air, output ready);
endinterface
`default_nettype wire

// ===== hdl/vvc_out_if.sv =====
// Result item channel of the voxel visibility cull block.
`default_nettype none
interface vvc_out_if;
  logic valid;
  logic ready;
  logic visible;
  logic range_error;

  modport source (output valid, visible, range_error, input ready);
  modport sink   (input valid, visible, range_error, output ready);
endinterface
`default_nettype wire

// ===== hdl/vvc_cfg_if.sv =====
// Configuration write channel of the voxel visibility cull block.
`default_nettype none
interface vvc_cfg_if;
  import vvc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/voxel_visibility_cull.sv =====
// Top level of the voxel visibility cull block: air map memory, sequencer and result register.
`default_nettype none
// The air map is held in one single-port memory of MAX_WIDTH * MAX_HEIGHT rows, one row per
// (y, z) pair and one bit per x, with registered read data. After reset the block sweeps
// the memory to all solid, one row a cycle; no item is accepted during that sweep, while
// configuration writes are taken at any time. A query reads the centre row and then, for an
// interior cell, the four rows above, below, north and south, one after another over the
// single memory port. A finished result waits in an output register, so the next item can be
// accepted while the result is still waiting to be taken.
module voxel_visibility_cull #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic  clk,
  input  wire logic  rst,
  vvc_in_if.sink     items,
  vvc_out_if.source  results,
  vvc_cfg_if.sink    cfg
);
  import vvc_pkg::*;

  localparam int ROWS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WEW  = ($clog2(MAX_WIDTH + 1) > CHUNK_WIDTH_W) ?
                        $clog2(MAX_WIDTH + 1) : CHUNK_WIDTH_W;
  localparam int HEW  = ($clog2(MAX_HEIGHT + 1) > CHUNK_HEIGHT_W) ?
                        $clog2(MAX_HEIGHT + 1) : CHUNK_HEIGHT_W;

  state_t state, state_next;

  logic [CHUNK_WIDTH_W-1:0]  chunk_width;
  logic [CHUNK_HEIGHT_W-1:0] chunk_height;

  // Item registers.
  opcode_t           op;
  logic [XW-1:0]     xi;
  logic              air;
  logic [AW-1:0]     row;
  logic              face;
  logic              err;
  logic              centre_air;
  logic              nb_air;
  logic [QRY_CNT_W-1:0] qcnt;
  logic [AW-1:0]     clr_addr;

  // Output register.
  logic out_valid;
  logic out_visible;
  logic out_error;

  // Memory port.
  logic [MAX_WIDTH-1:0] mem [ROWS];
  logic                 mem_en;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic [MAX_WIDTH-1:0] mem_rdata;

  logic in_acc;
  logic out_load;
  logic res_visible;

  // Effective chunk sizes and the checks made on an arriving item.
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic           in_err;
  logic           in_face;
  logic [AW-1:0]  in_row;

  assign w_eff = (WEW'(chunk_width) > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : WEW'(chunk_width);
  assign h_eff = (HEW'(chunk_height) > HEW'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) :
                 HEW'(chunk_height);

  assign in_err  = (WEW'(items.x_coord) >= w_eff) || (WEW'(items.z_coord) >= w_eff) ||
                   (HEW'(items.y_coord) >= h_eff);
  assign in_face = (items.x_coord == '0) || (WEW'(items.x_coord) == w_eff - WEW'(1)) ||
                   (items.z_coord == '0) || (WEW'(items.z_coord) == w_eff - WEW'(1)) ||
                   (items.y_coord == '0) || (HEW'(items.y_coord) == h_eff - HEW'(1));
  assign in_row  = AW'(items.y_coord) * AW'(MAX_WIDTH) + AW'(items.z_coord);

  assign in_acc   = items.valid && items.ready;
  assign out_load = (state == ST_DONE) && (!out_valid || results.ready);

  // The verdict: a solid cell that lies on a face or touches air.
  assign res_visible = (op == OP_QUERY) && !err && !centre_air && (face || nb_air);

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_width  <= CHUNK_WIDTH_RST;
      chunk_height <= CHUNK_HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CHUNK_WIDTH:  chunk_width  <= cfg.data[CHUNK_WIDTH_W-1:0];
        REG_CHUNK_HEIGHT: chunk_height <= cfg.data[CHUNK_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(ROWS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_err) state_next = ST_DONE;
          else if (items.opcode == OP_WRITE) state_next = ST_WRITE_RD;
          else state_next = ST_QUERY;
        end
      end
      ST_WRITE_RD: state_next = ST_WRITE_WB;
      ST_WRITE_WB: state_next = ST_DONE;
      ST_QUERY: begin
        if (qcnt == QRY_CNT_W'(QRY_READS)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: input handshake and memory port.
  always_comb begin
    items.ready = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = row;
    mem_wdata   = mem_rdata;
    unique case (state)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: items.ready = 1'b1;
      ST_WRITE_RD: mem_en = 1'b1;
      ST_WRITE_WB: begin
        mem_en        = 1'b1;
        mem_we        = 1'b1;
        mem_wdata[xi] = air;
      end
      ST_QUERY: begin
        // Neighbour rows are only needed for interior cells.
        mem_en = (qcnt == '0) || ((qcnt < QRY_CNT_W'(QRY_READS)) && !face);
        case (qcnt)
          QRY_CNT_W'(1): mem_addr = row - AW'(1);
          QRY_CNT_W'(2): mem_addr = row + AW'(1);
          QRY_CNT_W'(3): mem_addr = row - AW'(MAX_WIDTH);
          QRY_CNT_W'(4): mem_addr = row + AW'(MAX_WIDTH);
          default:       mem_addr = row;
        endcase
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // State, clearing sweep and query step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      qcnt     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == ST_QUERY) qcnt <= qcnt + QRY_CNT_W'(1);
      else qcnt <= '0;
    end
  end

  // Capture the item and gather the air flags as the rows come back.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op         <= items.opcode;
      xi         <= XW'(items.x_coord);
      air        <= items.is_air;
      row        <= in_row;
      face       <= in_face;
      err        <= in_err;
      centre_air <= 1'b0;
      nb_air     <= 1'b0;
    end else if (state == ST_QUERY && qcnt != '0) begin
      if (qcnt == QRY_CNT_W'(1)) begin
        centre_air <= mem_rdata[xi];
        nb_air     <= !face && (mem_rdata[xi - XW'(1)] || mem_rdata[xi + XW'(1)]);
      end else begin
        nb_air <= nb_air || (!face && mem_rdata[xi]);
      end
    end
  end

  // Single-port air map memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      else mem_rdata <= mem[mem_addr];
    end
  end

  // Result register, loaded when the slot is free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_visible <= res_visible;
      out_error   <= err;
    end
  end

  assign results.valid       = out_valid;
  assign results.visible     = out_visible;
  assign results.range_error = out_error;

`ifndef SYNTH
  // The map is written only by the clearing sweep and by a write-back.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_WRITE_WB))
    else $error("air map written outside clear or write-back");

  // A result never reports a visible cell together with a range error.
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.visible && results.range_error))
    else $error("visible result flagged out of range");

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != ST_IDLE))
    else $error("accepted item did not start work");
`endif

endmodule
`default_nettype wire
